// ===== rtl/core/lfps_pkg.sv =====
// Package for the line follower PID steering block.
// Holds register indexes, field widths and the tracker snapshot type.
// No dependencies.
`default_nettype none

package lfps_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned AccW = 35;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SENSOR_THRESHOLD = 3'd0,
		REG_BASE_SPEED       = 3'd1,
		REG_RIGHT_TRIM       = 3'd2,
		REG_INTEGRAL_LIMIT   = 3'd3,
		REG_PROP_GAIN        = 3'd4,
		REG_INTEG_GAIN       = 3'd5,
		REG_DERIV_GAIN       = 3'd6
	} cfg_reg_t;

	localparam logic [7:0]  RstSensorThreshold = 8'd13;
	localparam logic [7:0]  RstBaseSpeed       = 8'd160;
	localparam logic [7:0]  RstRightTrim       = 8'd35;
	localparam logic [14:0] RstIntegralLimit   = 15'd100;
	localparam logic [15:0] RstPropGain        = 16'd5120;
	localparam logic [15:0] RstIntegGain       = 16'd205;
	localparam logic [15:0] RstDerivGain       = 16'd13;

	typedef struct packed {
		logic signed [1:0]  err;
		logic signed [2:0]  deriv;
		logic signed [15:0] integ;
		logic               node;
	} snap_t;

endpackage

`default_nettype wire

// ===== rtl/core/line_follow_pid_steering.sv =====
// Line follower PID steering block, top level.
// Instantiates lfps_tracker; uses lfps_pkg.
//
// Usage:
//   Sample channel: sample_valid/sample_stall carry one beat of three
//   eight-bit reflectance samples. Duty channel: duty_valid/duty_stall
//   carry one beat of left and right wheel duty, held error and node flag.
//   A beat moves at a rising edge with valid high and stall low.
//   Each sample beat gives exactly one duty beat, in order.
//   The path runs through held state update, gain products, and duty
//   saturation and trim, each ending in a register.
//   Throughput is one beat per cycle while duty_stall is low; the state
//   update loop in the tracker is the only feedback path.
//   When duty_stall is high the pipeline holds; bubbles are filled first,
//   so up to three beats are held before sample_stall rises.
//   Reset clears the held state and all valid flags and loads the
//   register defaults. Write registers through cfg_write/cfg_index/cfg_data
//   only while no beat is in flight; indexes past the list are dropped.
`default_nettype none

module line_follow_pid_steering
	import lfps_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                sample_valid,
	output logic                     sample_stall,
	input  wire logic [7:0]          left_sample,
	input  wire logic [7:0]          center_sample,
	input  wire logic [7:0]          right_sample,
	output logic                     duty_valid,
	input  wire logic                duty_stall,
	output logic [7:0]               left_duty,
	output logic [7:0]               right_duty,
	output logic signed [1:0]        steer_error,
	output logic                     node_seen
);

	logic [7:0]  sensor_threshold_q;
	logic [7:0]  base_speed_q;
	logic [7:0]  right_trim_q;
	logic [14:0] integral_limit_q;
	logic [15:0] prop_gain_q;
	logic [15:0] integ_gain_q;
	logic [15:0] deriv_gain_q;

	logic  accept;
	logic  out_ready;
	logic  s2_ok;
	logic  s1_ok;
	snap_t snap;

	logic                   valid_s1;
	snap_t                  snap_s1;
	logic                   valid_s2;
	logic signed [AccW-1:0] acc_s2;
	logic signed [1:0]      err_s2;
	logic                   node_s2;
	logic                   valid_q;

	logic signed [AccW-1:0] p_term;
	logic signed [AccW-1:0] d_term;
	logic signed [32:0]     i_prod;
	logic signed [AccW-1:0] acc;

	logic [AccW-1:0] mag;
	logic [25:0]     pmag;
	logic [26:0]     up_sum;
	logic [7:0]      up_duty;
	logic [7:0]      down_duty;
	logic            slow_left;
	logic [7:0]      ld;
	logic [7:0]      rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_threshold_q <= RstSensorThreshold;
			base_speed_q <= RstBaseSpeed;
			right_trim_q <= RstRightTrim;
			integral_limit_q <= RstIntegralLimit;
			prop_gain_q <= RstPropGain;
			integ_gain_q <= RstIntegGain;
			deriv_gain_q <= RstDerivGain;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SENSOR_THRESHOLD: sensor_threshold_q <= cfg_data[7:0];
				REG_BASE_SPEED:       base_speed_q <= cfg_data[7:0];
				REG_RIGHT_TRIM:       right_trim_q <= cfg_data[7:0];
				REG_INTEGRAL_LIMIT:   integral_limit_q <= cfg_data[14:0];
				REG_PROP_GAIN:        prop_gain_q <= cfg_data;
				REG_INTEG_GAIN:       integ_gain_q <= cfg_data;
				REG_DERIV_GAIN:       deriv_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_ready = !valid_q || !duty_stall;
	assign s2_ok = !valid_s2 || out_ready;
	assign s1_ok = !valid_s1 || s2_ok;
	assign sample_stall = !s1_ok;
	assign accept = sample_valid && s1_ok;

	lfps_tracker u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.left_sample   (left_sample),
		.center_sample (center_sample),
		.right_sample  (right_sample),
		.threshold     (sensor_threshold_q),
		.limit         (integral_limit_q),
		.snap          (snap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (s1_ok)
				valid_s1 <= accept;
			if (s2_ok)
				valid_s2 <= valid_s1;
			if (out_ready)
				valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			snap_s1 <= snap;
	end

	always_comb begin
		unique case (snap_s1.err)
			2'sb01:  p_term = $signed({{(AccW-16){1'b0}}, prop_gain_q});
			2'sb11:  p_term = -$signed({{(AccW-16){1'b0}}, prop_gain_q});
			default: p_term = '0;
		endcase
		unique case (snap_s1.deriv)
			3'sb001: d_term = $signed({{(AccW-16){1'b0}}, deriv_gain_q});
			3'sb010: d_term = $signed({{(AccW-17){1'b0}}, deriv_gain_q, 1'b0});
			3'sb111: d_term = -$signed({{(AccW-16){1'b0}}, deriv_gain_q});
			3'sb110: d_term = -$signed({{(AccW-17){1'b0}}, deriv_gain_q, 1'b0});
			default: d_term = '0;
		endcase
		i_prod = $signed({1'b0, integ_gain_q}) * snap_s1.integ;
		acc = p_term + d_term + AccW'(i_prod);
	end

	always_ff @(posedge clk) begin
		if (s2_ok && valid_s1) begin
			acc_s2 <= acc;
			err_s2 <= snap_s1.err;
			node_s2 <= snap_s1.node;
		end
	end

	always_comb begin
		mag = acc_s2[AccW-1] ? AccW'(-acc_s2) : AccW'(acc_s2);
		pmag = mag[33:8];
		up_sum = {19'd0, base_speed_q} + {1'b0, pmag};
		up_duty = (up_sum > 27'd255) ? 8'd255 : up_sum[7:0];
		down_duty = ({18'd0, base_speed_q} < pmag) ? 8'd0
			: 8'(up_sum - {pmag, 1'b0});
		slow_left = (err_s2 < 0) || (acc_s2[AccW-1]);
		if (err_s2 == 2'sb00) begin
			ld = base_speed_q;
			rd = base_speed_q;
		end else if (slow_left) begin
			ld = down_duty;
			rd = up_duty;
		end else begin
			ld = up_duty;
			rd = down_duty;
		end
		if (rd > right_trim_q)
			rd = rd - right_trim_q;
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			left_duty <= ld;
			right_duty <= rd;
			steer_error <= err_s2;
			node_seen <= node_s2;
		end
	end

	assign duty_valid = valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/lfps_tracker.sv =====
// Sensor thresholding and held steering state (error, derivative, integrator).
// Produces the updated state of the accepted beat; uses lfps_pkg.
`default_nettype none

module lfps_tracker
	import lfps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  left_sample,
	input  wire logic [7:0]  center_sample,
	input  wire logic [7:0]  right_sample,
	input  wire logic [7:0]  threshold,
	input  wire logic [14:0] limit,
	output snap_t            snap
);

	logic signed [1:0]  err_q;
	logic signed [2:0]  deriv_q;
	logic signed [15:0] integ_q;

	logic               l_on;
	logic               c_on;
	logic               r_on;
	logic [1:0]         count;
	logic               one_hot;
	logic signed [1:0]  err_n;
	logic signed [2:0]  deriv_n;
	logic signed [15:0] integ_c;
	logic signed [16:0] isum;
	logic signed [15:0] integ_n;

	always_comb begin
		l_on = left_sample > threshold;
		c_on = center_sample > threshold;
		r_on = right_sample > threshold;
		count = {1'b0, l_on} + {1'b0, c_on} + {1'b0, r_on};
		one_hot = count == 2'd1;
		err_n = err_q;
		deriv_n = deriv_q;
		integ_c = integ_q;
		if (one_hot) begin
			err_n = $signed({1'b0, r_on}) - $signed({1'b0, l_on});
			deriv_n = 3'(err_n) - 3'(err_q);
			if (integ_q > $signed({1'b0, limit}))
				integ_c = $signed({1'b0, limit});
		end
		isum = 17'(integ_c) + 17'(err_n);
		if (isum > 17'sd32767)
			integ_n = 16'sh7fff;
		else if (isum < -17'sd32768)
			integ_n = 16'sh8000;
		else
			integ_n = isum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0;
			deriv_q <= '0;
			integ_q <= '0;
		end else if (accept) begin
			err_q <= err_n;
			deriv_q <= deriv_n;
			integ_q <= integ_n;
		end
	end

	assign snap = '{err: err_n, deriv: deriv_n, integ: integ_n, node: count[1]};

endmodule

`default_nettype wire

// ===== tb/lfps_duty_checker.sv =====
`timescale 1ns / 1ps
// Duty channel checker for line_follow_pid_steering: tracks the register
// shadow and steering state, predicts each duty beat and compares it.
// Depends on lfps_pkg for the register indexes and reset values.

module lfps_duty_checker
	import lfps_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                sample_valid,
	input  wire logic                sample_stall,
	input  wire logic [7:0]          left_sample,
	input  wire logic [7:0]          center_sample,
	input  wire logic [7:0]          right_sample,
	input  wire logic                duty_valid,
	input  wire logic                duty_stall,
	input  wire logic [7:0]          left_duty,
	input  wire logic [7:0]          right_duty,
	input  wire logic signed [1:0]   steer_error,
	input  wire logic                node_seen,
	output int                       mismatches,
	output int                       outstanding,
	output int                       duties_checked
);

	typedef struct packed {
		logic [7:0]        left_d;
		logic [7:0]        right_d;
		logic signed [1:0] err;
		logic              node;
	} duty_t;

	logic [7:0]  thr, base_spd, trim;
	logic [14:0] integ_limit;
	logic [15:0] kp, ki, kd;

	logic signed [1:0]  trk_err, trk_prev;
	logic signed [2:0]  trk_deriv;
	logic signed [15:0] trk_integ;

	duty_t pending_duties[$];
	duty_t want;

	function automatic logic [7:0] sat_duty(input longint v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return 8'(v);
	endfunction

	function automatic duty_t predict_duty(input logic [7:0] ls, cs, rs);
		logic   on_l, on_c, on_r;
		int     lit, isum;
		longint acc, mag, p, lw, rw;
		duty_t  d;
		on_l = ls > thr;
		on_c = cs > thr;
		on_r = rs > thr;
		lit = int'(on_l) + int'(on_c) + int'(on_r);
		if (lit == 1) begin
			trk_err = 2'(int'(on_r) - int'(on_l));
			trk_deriv = 3'(int'(trk_err) - int'(trk_prev));
			if (int'(trk_integ) > int'(integ_limit))
				trk_integ = 16'(integ_limit);
			trk_prev = trk_err;
		end
		isum = int'(trk_integ) + int'(trk_err);
		if (isum > 32767)
			isum = 32767;
		if (isum < -32768)
			isum = -32768;
		trk_integ = 16'(isum);

		acc = longint'(kp) * longint'(trk_err) + longint'(kd) * longint'(trk_deriv)
			+ longint'(ki) * longint'(trk_integ);
		mag = (acc < 0) ? -acc : acc;
		p = mag >>> 8;
		if (trk_err < 0) begin
			lw = longint'(base_spd) - p;
			rw = longint'(base_spd) + p;
		end else if (trk_err > 0) begin
			if (acc < 0)
				p = -p;
			lw = longint'(base_spd) + p;
			rw = longint'(base_spd) - p;
		end else begin
			lw = longint'(base_spd);
			rw = longint'(base_spd);
		end
		d.left_d = sat_duty(lw);
		d.right_d = sat_duty(rw);
		if (d.right_d > trim)
			d.right_d = d.right_d - trim;
		d.err = trk_err;
		d.node = lit >= 2;
		return d;
	endfunction

	task automatic report(input string msg);
		$display("%0t ns duty check: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr = RstSensorThreshold;
			base_spd = RstBaseSpeed;
			trim = RstRightTrim;
			integ_limit = RstIntegralLimit;
			kp = RstPropGain;
			ki = RstIntegGain;
			kd = RstDerivGain;
			trk_err = '0;
			trk_prev = '0;
			trk_deriv = '0;
			trk_integ = '0;
			pending_duties.delete();
			mismatches = 0;
			outstanding = 0;
			duties_checked = 0;
		end else begin
			if (duty_valid && !duty_stall) begin
				if (pending_duties.size() == 0) begin
					report("duty beat with no sample beat waiting");
				end else begin
					want = pending_duties.pop_front();
					if (left_duty !== want.left_d)
						report($sformatf("beat %0d left_duty %0d, expected %0d",
							duties_checked, left_duty, want.left_d));
					if (right_duty !== want.right_d)
						report($sformatf("beat %0d right_duty %0d, expected %0d",
							duties_checked, right_duty, want.right_d));
					if (steer_error !== want.err)
						report($sformatf("beat %0d steer_error %0d, expected %0d",
							duties_checked, steer_error, want.err));
					if (node_seen !== want.node)
						report($sformatf("beat %0d node_seen %0b, expected %0b",
							duties_checked, node_seen, want.node));
					duties_checked++;
				end
			end
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_SENSOR_THRESHOLD: thr = cfg_data[7:0];
					REG_BASE_SPEED:       base_spd = cfg_data[7:0];
					REG_RIGHT_TRIM:       trim = cfg_data[7:0];
					REG_INTEGRAL_LIMIT:   integ_limit = cfg_data[14:0];
					REG_PROP_GAIN:        kp = cfg_data;
					REG_INTEG_GAIN:       ki = cfg_data;
					REG_DERIV_GAIN:       kd = cfg_data;
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall)
				pending_duties.push_back(predict_duty(left_sample, center_sample,
					right_sample));
			outstanding = pending_duties.size();
		end
	end

endmodule

// ===== tb/line_follow_pid_steering_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for line_follow_pid_steering: clock, reset, register setup,
// sample stimulus and duty back-pressure; lfps_duty_checker does the checking.
// Depends on lfps_pkg, line_follow_pid_steering and lfps_duty_checker.

module line_follow_pid_steering_tb;
	import lfps_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
	localparam int DRIFT_BEATS = 10;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_write;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                sample_valid;
	logic                sample_stall;
	logic [7:0]          left_sample, center_sample, right_sample;
	logic                duty_valid;
	logic                duty_stall;
	logic [7:0]          left_duty, right_duty;
	logic signed [1:0]   steer_error;
	logic                node_seen;

	int mismatches, outstanding, duties_checked;
	int beats_sent = 0;
	int settings_used = 0;
	int hold_request = 0;
	bit gaps_on = 1'b1;
	logic [7:0] cur_thr = RstSensorThreshold;

	line_follow_pid_steering uut (.*);

	lfps_duty_checker duty_check (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#5ms;
		$display("line_follow_pid_steering_tb: done, errors");
		$finish;
	end

	// duty side back-pressure; hold requests are counted down here
	initial begin
		int hold_left;
		hold_left = 0;
		duty_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				duty_stall <= 1'b1;
				hold_left--;
			end else begin
				duty_stall <= gaps_on && ($urandom_range(99) < 17);
			end
		end
	end

	task automatic send_beat(input logic [7:0] ls, cs, rs);
		if (gaps_on && $urandom_range(99) < 17) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		left_sample <= ls;
		center_sample <= cs;
		right_sample <= rs;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] thr, base, trim,
			input logic [14:0] lim, input logic [15:0] kp, ki, kd);
		put_reg(REG_SENSOR_THRESHOLD, 16'(thr));
		put_reg(REG_BASE_SPEED, 16'(base));
		put_reg(REG_RIGHT_TRIM, 16'(trim));
		put_reg(REG_INTEGRAL_LIMIT, 16'(lim));
		put_reg(REG_PROP_GAIN, kp);
		put_reg(REG_INTEG_GAIN, ki);
		put_reg(REG_DERIV_GAIN, kd);
		put_reg(REG_UNUSED, 16'($urandom));
		cfg_write <= 1'b0;
		@(posedge clk);
		cur_thr = thr;
		settings_used++;
	endtask

	function automatic logic [7:0] line_level(input bit lit);
		if (lit && cur_thr < 8'd255)
			return 8'($urandom_range(255, int'(cur_thr) + 1));
		if (!lit)
			return 8'($urandom_range(int'(cur_thr), 0));
		return 8'($urandom);
	endfunction

	task automatic send_random();
		int sel;
		logic [2:0] mask;
		sel = $urandom_range(99);
		if (sel < 20) begin
			send_beat(8'($urandom), 8'($urandom), 8'($urandom));
		end else begin
			mask = (sel < 65) ? (3'b001 << $urandom_range(2)) : 3'($urandom);
			send_beat(line_level(mask[2]), line_level(mask[1]), line_level(mask[0]));
		end
	endtask

	initial begin
		int ph, i;
		sample_valid = 1'b0;
		left_sample = '0;
		center_sample = '0;
		right_sample = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send_beat(8'd0, 8'd0, 8'd0);
		send_beat(8'd13, 8'd13, 8'd13);
		send_beat(8'd14, 8'd0, 8'd0);
		send_beat(8'd255, 8'd0, 8'd0);
		send_beat(8'd0, 8'd255, 8'd0);
		send_beat(8'd0, 8'd0, 8'd14);
		send_beat(8'd0, 8'd0, 8'd255);
		send_beat(8'd255, 8'd0, 8'd0);
		send_beat(8'd0, 8'd0, 8'd255);
		send_beat(8'd255, 8'd255, 8'd0);
		send_beat(8'd0, 8'd255, 8'd255);
		send_beat(8'd255, 8'd0, 8'd255);
		send_beat(8'd255, 8'd255, 8'd255);
		send_beat(8'd170, 8'd85, 8'd0);
		send_beat(8'd85, 8'd0, 8'd170);
		send_beat(8'd1, 8'd2, 8'd4);
		send_beat(8'd0, 8'd170, 8'd0);
		drain();

		for (ph = 0; ph < 9; ph++) begin
			case (ph)
				0: program_regs(RstSensorThreshold, RstBaseSpeed, RstRightTrim,
					RstIntegralLimit, RstPropGain, RstIntegGain, RstDerivGain);
				1: program_regs(8'd0, 8'd0, 8'd0, 15'd0, 16'd0, 16'd0, 16'd0);
				2: program_regs(8'd255, 8'd255, 8'd255, 15'h7fff, 16'hffff, 16'hffff, 16'hffff);
				3: program_regs(8'd128, 8'd255, 8'd0, 15'h7fff, 16'hffff, 16'hffff, 16'hffff);
				4: program_regs(8'd100, 8'd0, 8'd255, 15'd0, 16'hffff, 16'd0, 16'hffff);
				default: program_regs(8'($urandom_range(200)), 8'($urandom), 8'($urandom),
					15'($urandom), 16'($urandom), 16'($urandom_range(2048)), 16'($urandom));
			endcase
			gaps_on = (ph != 5);
			if (ph == 3)
				hold_request = 80;
			for (i = 0; i < 90; i++) begin
				send_random();
				if (ph == 4 && i == 47)
					drain();
			end
			drain();
		end

		// walk the integrator down and up, then clamp from the top
		gaps_on = 1'b0;
		program_regs(RstSensorThreshold, RstBaseSpeed, RstRightTrim,
			15'd0, RstPropGain, RstIntegGain, RstDerivGain);
		send_beat(8'd200, 8'd0, 8'd0);
		for (i = 0; i < DRIFT_BEATS; i++)
			send_beat(8'd0, 8'd0, 8'd0);
		send_beat(8'd0, 8'd0, 8'd200);
		for (i = 0; i < DRIFT_BEATS; i++)
			send_beat(8'd200, 8'd200, 8'd0);
		send_beat(8'd200, 8'd0, 8'd0);
		send_beat(8'd0, 8'd0, 8'd0);
		drain();
		repeat (8) @(posedge clk);

		$display("%0d sample beats over %0d register settings, with stalls, a full hold-off",
			beats_sent, settings_used + 1);
		$display("and an integrator walk clamped from the top; %0d duty beats compared",
			duties_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("line_follow_pid_steering_tb: done, clean");
		else
			$display("line_follow_pid_steering_tb: done, errors");
		$finish;
	end

endmodule
